// ----- rtl/dssu_pkg.sv -----
// Package with the types, codes and constants shared by the dual stack store unit.
package dssu_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CntW = 6;
  localparam int unsigned DefaultDepth = 32;
  localparam logic [CntW-1:0] StoreSizeReset = 6'd32;

  localparam logic OpPush = 1'b0;
  localparam logic OpPop = 1'b1;
  localparam logic SelLower = 1'b0;
  localparam logic SelUpper = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic             opcode;
    logic             stack_select;
    logic [DataW-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic [DataW-1:0] pop_value;
    logic [1:0]       status;
  } out_item_t;

  typedef struct packed {
    logic exec;
    logic load;
  } dssu_cmd_t;

  typedef struct packed {
    logic pop_ok;
  } dssu_sts_t;

endpackage

// ----- rtl/dssu_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module dssu_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/dssu_datapath.sv -----
// Datapath holding the size register, both stack counts, the shared store and the result.
module dssu_datapath #(
  parameter int unsigned StoreDepth = dssu_pkg::DefaultDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [dssu_pkg::CntW-1:0]    cfg_wdata_i,
  input  dssu_pkg::in_item_t           in_data_i,
  input  dssu_pkg::dssu_cmd_t          cmd_i,
  output dssu_pkg::dssu_sts_t          sts_o,
  output dssu_pkg::out_item_t          out_data_o
);

  localparam int unsigned AddrW = $clog2(StoreDepth);
  localparam int unsigned CntW = dssu_pkg::CntW;

  logic [CntW-1:0] size_q;
  logic [CntW-1:0] lower_q, lower_d;
  logic [CntW-1:0] upper_q, upper_d;
  logic [CntW-1:0] used;
  logic [CntW:0]   fill;
  logic            full;
  logic            lower_empty;
  logic            upper_empty;
  logic            is_pop;
  logic            is_upper;
  logic            push_ok;
  logic            pop_ok;
  logic [CntW-1:0] slot;
  logic [1:0]      status;
  logic [dssu_pkg::DataW-1:0] rdata;
  dssu_pkg::out_item_t out_q;

  always_comb begin
    if (int'(size_q) > StoreDepth) begin
      used = CntW'(StoreDepth);
    end else begin
      used = size_q;
    end
  end

  assign fill        = {1'b0, lower_q} + {1'b0, upper_q};
  assign full        = fill >= {1'b0, used};
  assign lower_empty = lower_q == '0;
  assign upper_empty = (upper_q == '0) || (upper_q > used);
  assign is_pop      = in_data_i.opcode == dssu_pkg::OpPop;
  assign is_upper    = in_data_i.stack_select == dssu_pkg::SelUpper;
  assign push_ok     = !is_pop && !full;
  assign pop_ok      = is_pop && (is_upper ? !upper_empty : !lower_empty);

  always_comb begin
    lower_d = lower_q;
    upper_d = upper_q;
    slot    = lower_q;
    status  = dssu_pkg::STATUS_OK;
    unique case ({is_pop, is_upper})
      {dssu_pkg::OpPush, dssu_pkg::SelLower}: begin
        slot = lower_q;
        if (full) begin
          status = dssu_pkg::STATUS_OVERFLOW;
        end else begin
          lower_d = lower_q + 1'b1;
        end
      end
      {dssu_pkg::OpPush, dssu_pkg::SelUpper}: begin
        slot = used - upper_q - 1'b1;
        if (full) begin
          status = dssu_pkg::STATUS_OVERFLOW;
        end else begin
          upper_d = upper_q + 1'b1;
        end
      end
      {dssu_pkg::OpPop, dssu_pkg::SelLower}: begin
        slot = lower_q - 1'b1;
        if (lower_empty) begin
          status = dssu_pkg::STATUS_UNDERFLOW;
        end else begin
          lower_d = lower_q - 1'b1;
        end
      end
      default: begin
        slot = used - upper_q;
        if (upper_empty) begin
          status = dssu_pkg::STATUS_UNDERFLOW;
        end else begin
          upper_d = upper_q - 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= dssu_pkg::StoreSizeReset;
      lower_q <= '0;
      upper_q <= '0;
    end else if (cfg_we_i) begin
      size_q  <= cfg_wdata_i;
      lower_q <= '0;
      upper_q <= '0;
    end else if (cmd_i.exec) begin
      lower_q <= lower_d;
      upper_q <= upper_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_q.pop_value <= '0;
      out_q.status    <= status;
    end else if (cmd_i.load) begin
      out_q.pop_value <= rdata;
    end
  end

  dssu_ram #(
    .Width(dssu_pkg::DataW),
    .Depth(StoreDepth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.exec && push_ok),
    .waddr_i(AddrW'(slot)),
    .wdata_i(in_data_i.push_value),
    .re_i   (cmd_i.exec && pop_ok),
    .raddr_i(AddrW'(slot)),
    .rdata_o(rdata)
  );

  assign sts_o.pop_ok = pop_ok;
  assign out_data_o   = out_q;

endmodule

// ----- rtl/dssu_ctrl.sv -----
// Controller state machine sequencing accept, store read and result handoff.
module dssu_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  dssu_pkg::dssu_sts_t sts_i,
  output dssu_pkg::dssu_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_OUT
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;
  logic   accept;

  assign accept     = in_valid_i && in_ready_q;
  assign cmd_o.exec = accept;
  assign cmd_o.load = state_q == ST_READ;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            in_ready_q <= 1'b0;
            if (sts_i.pop_ok) begin
              state_q <= ST_READ;
            end else begin
              state_q     <= ST_OUT;
              out_valid_q <= 1'b1;
            end
          end
        end
        ST_READ: begin
          state_q     <= ST_OUT;
          out_valid_q <= 1'b1;
        end
        default: begin
          if (out_ready_i) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b0;
            in_ready_q  <= 1'b1;
          end
        end
      endcase
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/dual_stack_shared_store_unit.sv -----
// Top level of the dual stack shared store unit.
//
// Two stacks share one store: the lower stack grows upward from entry 0, the
// upper stack grows downward from the top of the register size, capped at the store depth.
// Each input item is a push or a pop on one stack; each item gives exactly one
// result item with the popped word and a status of ok, overflow or underflow.
// Both channels use valid and ready. A push or a refused operation offers its
// result in the cycle after acceptance, and a successful pop only after the read
// state, because the word comes out of the registered read port of the store.
// One item is worked on at a time, so the input is not ready again until the
// result has been taken. While the receiver stalls, the result holds.
// A write on the size port empties both stacks and must come while idle.
// Reset empties both stacks and sets the size to 32; no clearing pass runs,
// since a pop reads only entries pushed since the last emptying.
module dual_stack_shared_store_unit #(
  parameter int unsigned StoreDepth = dssu_pkg::DefaultDepth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [dssu_pkg::CntW-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  dssu_pkg::in_item_t        in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output dssu_pkg::out_item_t       out_data_o
);

  dssu_pkg::dssu_cmd_t cmd;
  dssu_pkg::dssu_sts_t sts;

  dssu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dssu_datapath #(
    .StoreDepth(StoreDepth)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

  // The block never holds a new item while a result is being offered.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is offered");

  // An accepted item closes the input until its result is taken.
  a_accept_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input still ready after an item was accepted");

  // A refused operation returns a zero word.
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status != dssu_pkg::STATUS_OK)) |->
      (out_data_o.pop_value == '0))
    else $error("refused operation returned a nonzero word");

endmodule
